// ===== rtl/mdc_pkg.sv =====
// Shared constants for the message deframer and checksum checker.
package mdc_pkg;

  // Result kinds carried on the output tuser
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_OK   = 2'd1;
  localparam logic [1:0] KIND_BAD  = 2'd2;
  localparam logic [1:0] KIND_ZERO = 2'd3;

  localparam int unsigned LENGTH_BITS_DEFAULT = 32;
  localparam logic [7:0]  XOR_KEY_RESET       = 8'h55;
  localparam int unsigned HEADER_BYTES        = 4;

  // One result entry of the output buffer
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
  } result_t;

endpackage

// ===== rtl/message_deframer_checker.sv =====
// Length-prefixed frame deframer with XOR unmasking and additive checksum check.
//
// Takes one stream byte per cycle, back to back, while tready is high, with
// registered results. Each frame is a 4-byte big-endian length (truncated to
// LENGTH_BITS), then that many payload bytes masked with xor_key. Payload
// bytes but the last come out as unmasked data (tuser kind 0); the last one is
// compared with the 8-bit sum of the data and ends the frame with kind 1 (ok)
// or kind 2 (mismatch). A zero length gives kind 3 and the block goes back to
// expecting a header. Other header bytes produce no output. Each accepted byte
// updates the frame state; a two-entry output buffer (result register plus
// skid entry) keeps the input side going while a result waits, so tready on
// the input drops only while both entries are full. xor_key may be written at
// any idle time and applies from the next byte.
module message_deframer_checker #(
  parameter int unsigned LENGTH_BITS = mdc_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  // input stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  // output stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] data
  output logic [1:0] m_axis_tuser,   // [1:0] kind
  // key register write
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data        // [7:0] xor_key
);

  localparam int unsigned HC_BITS = $clog2(mdc_pkg::HEADER_BYTES);
  localparam logic [HC_BITS-1:0] HC_LAST = HC_BITS'(mdc_pkg::HEADER_BYTES - 1);

  logic [7:0]             xor_key;
  logic                   in_payload, in_payload_next;
  logic [HC_BITS-1:0]     header_count, header_count_next;
  // Length register: assembles the header, then counts payload bytes down
  logic [LENGTH_BITS-1:0] len, len_next;
  logic [7:0]             running_sum, running_sum_next;

  logic                   out_valid, skid_valid;
  mdc_pkg::result_t       out_res, skid_res;

  logic                   in_xact, out_xact;
  logic                   res_valid;
  mdc_pkg::result_t       res;
  logic [7:0]             plain;
  logic [LENGTH_BITS-1:0] len_shift;

  assign s_axis_tready = !skid_valid;
  assign in_xact       = s_axis_tvalid && s_axis_tready;
  assign out_xact      = out_valid && m_axis_tready;
  assign cfg_ready     = 1'b1;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_res.data;
  assign m_axis_tuser  = out_res.kind;

  // Key register
  always_ff @(posedge clk) begin
    if (rst) begin
      xor_key <= mdc_pkg::XOR_KEY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      xor_key <= cfg_data;
    end
  end

  assign plain     = s_axis_tdata ^ xor_key;
  assign len_shift = (len << 8) | LENGTH_BITS'(s_axis_tdata);

  // Per-byte frame state update and result
  always_comb begin
    in_payload_next   = in_payload;
    header_count_next = header_count;
    len_next          = len;
    running_sum_next  = running_sum;
    res_valid         = 1'b0;
    res.kind          = mdc_pkg::KIND_DATA;
    res.data          = 8'h00;
    if (!in_payload) begin
      len_next = len_shift;
      if (header_count != HC_LAST) begin
        header_count_next = header_count + HC_BITS'(1);
      end else begin
        header_count_next = '0;
        if (len_shift == '0) begin
          res_valid = 1'b1;
          res.kind  = mdc_pkg::KIND_ZERO;
        end else begin
          in_payload_next  = 1'b1;
          running_sum_next = 8'h00;
        end
      end
    end else begin
      res_valid = 1'b1;
      if (len[LENGTH_BITS-1:1] == '0) begin
        // last payload byte is the checksum
        res.kind        = (plain == running_sum) ? mdc_pkg::KIND_OK : mdc_pkg::KIND_BAD;
        in_payload_next = 1'b0;
        len_next        = '0;
      end else begin
        len_next         = len - LENGTH_BITS'(1);
        running_sum_next = running_sum + plain;
        res.data         = plain;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_payload   <= 1'b0;
      header_count <= '0;
      len          <= '0;
      running_sum  <= 8'h00;
    end else if (in_xact) begin
      in_payload   <= in_payload_next;
      header_count <= header_count_next;
      len          <= len_next;
      running_sum  <= running_sum_next;
    end
  end

  // Output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_xact) begin
          skid_valid <= 1'b0;
        end
      end else if (in_xact && res_valid && out_valid && !m_axis_tready) begin
        skid_valid <= 1'b1;
      end
      if (!out_valid || m_axis_tready) begin
        out_valid <= skid_valid || (in_xact && res_valid);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_axis_tready) begin
      out_res <= skid_valid ? skid_res : res;
    end
    if (!skid_valid) begin
      skid_res <= res;
    end
  end

  // Checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while result register empty");

  a_skid_from_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !m_axis_tready && in_xact))
    else $error("skid entry filled without a stalled result");

  a_header_idle_in_payload: assert property (@(posedge clk) disable iff (rst)
    in_payload |-> (header_count == '0 && len != '0))
    else $error("payload state with header count or empty length");

  a_data_only_in_payload: assert property (@(posedge clk) disable iff (rst)
    (in_xact && !in_payload) |=> (!out_valid || out_res.kind != mdc_pkg::KIND_DATA
                                  || $past(out_valid && !m_axis_tready) || $past(skid_valid)))
    else $error("data result from a header byte");

endmodule
